@@ rtl/dbd_pkg.sv @@
// Shared widths, constants and calendar functions for the date difference block.
package dbd_pkg;

   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 14;
   localparam int YLIM_W     = 15;
   localparam int COUNT_W    = 22;
   localparam int DNUM_W     = 23;
   localparam int OFF_W      = 9;
   localparam int LEAPS_W    = 13;
   localparam int RECIP_W    = 13;
   localparam int PROD_W     = YEAR_W + RECIP_W;
   localparam int RECIP_SH   = 19;
   localparam int QUOT_W     = PROD_W - RECIP_SH;

   localparam int MAX_YEAR_DEFAULT = 9999;

   // floor(n / 100) == (n * RECIP_100) >> RECIP_SH for all 14-bit n
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam logic [DNUM_W-1:0]  DAYS_PER_YEAR = 23'd365;
   localparam logic [YLIM_W-1:0]  CENTURY = 15'd100;

   localparam logic [MONTH_W-1:0] JANUARY   = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
   localparam logic [MONTH_W-1:0] MARCH     = 4'd3;
   localparam logic [MONTH_W-1:0] APRIL     = 4'd4;
   localparam logic [MONTH_W-1:0] MAY       = 4'd5;
   localparam logic [MONTH_W-1:0] JUNE      = 4'd6;
   localparam logic [MONTH_W-1:0] JULY      = 4'd7;
   localparam logic [MONTH_W-1:0] AUGUST    = 4'd8;
   localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
   localparam logic [MONTH_W-1:0] OCTOBER   = 4'd10;
   localparam logic [MONTH_W-1:0] NOVEMBER  = 4'd11;
   localparam logic [MONTH_W-1:0] DECEMBER  = 4'd12;

   typedef struct packed {
      logic              ok;
      logic [DNUM_W-1:0] num;
   } daynum_type;

   function automatic logic [OFF_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [OFF_W-1:0] r;
      unique case (m)
         JANUARY:   r = 9'd0;
         FEBRUARY:  r = 9'd31;
         MARCH:     r = 9'd59;
         APRIL:     r = 9'd90;
         MAY:       r = 9'd120;
         JUNE:      r = 9'd151;
         JULY:      r = 9'd181;
         AUGUST:    r = 9'd212;
         SEPTEMBER: r = 9'd243;
         OCTOBER:   r = 9'd273;
         NOVEMBER:  r = 9'd304;
         DECEMBER:  r = 9'd334;
         default:   r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] r;
      unique case (m)
         FEBRUARY:                           r = leap ? 5'd29 : 5'd28;
         APRIL, JUNE, SEPTEMBER, NOVEMBER:   r = 5'd30;
         JANUARY, MARCH, MAY, JULY, AUGUST,
         OCTOBER, DECEMBER:                  r = 5'd31;
         default:                            r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/dbd_daynum.sv @@
// Three-stage pipeline turning one date into a day number plus a validity flag.
module dbd_daynum
   import dbd_pkg::*;
#(
   parameter int MAX_YEAR = MAX_YEAR_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [DAY_W-1:0]   day,
   input  logic [MONTH_W-1:0] month,
   input  logic [YEAR_W-1:0]  year,
   output logic               out_valid,
   output daynum_type         result
);

   // stage 1: reciprocal quotients by 100
   logic               v1_ff, v1_in;
   logic [DAY_W-1:0]   d1_ff;
   logic [MONTH_W-1:0] m1_ff;
   logic [YEAR_W-1:0]  y1_ff;
   logic               yok1_ff, yok1_in;
   logic [QUOT_W-1:0]  qx1_ff, qx1_in;
   logic [QUOT_W-1:0]  qy1_ff, qy1_in;
   logic [YEAR_W-1:0]  xs0;
   logic [PROD_W-1:0]  px0, py0;

   assign v1_in   = in_valid;
   assign xs0     = year - YEAR_W'(1);
   assign px0     = PROD_W'(xs0) * PROD_W'(RECIP_100);
   assign py0     = PROD_W'(year) * PROD_W'(RECIP_100);
   assign qx1_in  = px0[PROD_W-1:RECIP_SH];
   assign qy1_in  = py0[PROD_W-1:RECIP_SH];
   assign yok1_in = (year != '0) && (YLIM_W'(year) <= YLIM_W'(MAX_YEAR));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff   <= day;
      m1_ff   <= month;
      y1_ff   <= year;
      yok1_ff <= yok1_in;
      qx1_ff  <= qx1_in;
      qy1_ff  <= qy1_in;
   end

   // stage 2: leap rule, year base, month offset, validity
   logic               v2_ff, v2_in;
   logic               ok2_ff, ok2_in;
   logic [DNUM_W-1:0]  base2_ff, base2_in;
   logic [OFF_W-1:0]   off2_ff, off2_in;
   logic [YEAR_W-1:0]  xs1;
   logic               cent1, leap1, mok1, dok1;
   logic [LEAPS_W-1:0] leaps1;
   logic [DAY_W-1:0]   mlen1;

   always_comb begin
      xs1    = y1_ff - YEAR_W'(1);
      cent1  = (YLIM_W'(qy1_ff) * CENTURY) == YLIM_W'(y1_ff);
      leap1  = cent1 ? (qy1_ff[1:0] == 2'b00) : (y1_ff[1:0] == 2'b00);
      leaps1 = LEAPS_W'(xs1[YEAR_W-1:2]) - LEAPS_W'(qx1_ff)
             + LEAPS_W'(qx1_ff[QUOT_W-1:2]) + LEAPS_W'(1);
      mlen1  = month_len(m1_ff, leap1);
      mok1   = (m1_ff >= JANUARY) && (m1_ff <= DECEMBER);
      dok1   = (d1_ff != '0) && (d1_ff <= mlen1);
      ok2_in = yok1_ff && mok1 && dok1;
      base2_in = DNUM_W'(y1_ff) * DAYS_PER_YEAR + DNUM_W'(leaps1);
      off2_in  = days_before(m1_ff) + OFF_W'(d1_ff)
               + OFF_W'((m1_ff > FEBRUARY) && leap1);
      v2_in  = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      ok2_ff   <= ok2_in;
      base2_ff <= base2_in;
      off2_ff  <= off2_in;
   end

   // stage 3: final sum
   logic       v3_ff;
   daynum_type r3_ff, r3_in;

   assign r3_in.ok  = ok2_ff;
   assign r3_in.num = base2_ff + DNUM_W'(off2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      r3_ff <= r3_in;
   end

   assign out_valid = v3_ff;
   assign result    = r3_ff;

endmodule

@@ rtl/dbd_diff.sv @@
// Final stage: subtract day numbers, clamp at zero, add end day, mask invalid dates.
module dbd_diff
   import dbd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  daynum_type         from_date,
   input  daynum_type         to_date,
   input  logic               include_end,
   output logic               out_valid,
   output logic [COUNT_W-1:0] count,
   output logic               invalid
);

   logic               valid_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               invalid_ff, invalid_in;
   logic [DNUM_W-1:0]  span;

   always_comb begin
      invalid_in = !(from_date.ok && to_date.ok);
      span       = (from_date.num < to_date.num) ? (to_date.num - from_date.num) : '0;
      count_in   = invalid_in ? '0 : (span[COUNT_W-1:0] + COUNT_W'(include_end));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      invalid_ff <= invalid_in;
   end

   assign out_valid = valid_ff;
   assign count     = count_ff;
   assign invalid   = invalid_ff;

endmodule

@@ rtl/days_between_dates_top.sv @@
// Top level of the Gregorian date difference pipeline.
//
//   channel   ports                       handshake
//   request   req_* fields                start high, busy low
//   response  rsp_day_count, rsp_date_invalid   rsp_valid, one cycle, no back-pressure
//
// One transaction per cycle; each result passes through three day-number stages
// per date and then through one difference stage.
// busy stays low: the pipeline never stalls since the receiver cannot hold results.
// Synchronous reset clears the valid bits only; payload registers are not reset.
module days_between_dates_top
   import dbd_pkg::*;
#(
   parameter int MAX_YEAR = MAX_YEAR_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [DAY_W-1:0]   req_start_day,
   input  logic [MONTH_W-1:0] req_start_month,
   input  logic [YEAR_W-1:0]  req_start_year,
   input  logic [DAY_W-1:0]   req_end_day,
   input  logic [MONTH_W-1:0] req_end_month,
   input  logic [YEAR_W-1:0]  req_end_year,
   input  logic               req_include_end_day,
   output logic               rsp_valid,
   output logic [COUNT_W-1:0] rsp_day_count,
   output logic               rsp_date_invalid
);

   localparam int INC_STAGES = 3;

   logic                  accept;
   logic                  from_valid, to_valid;
   daynum_type            from_num, to_num;
   logic [INC_STAGES-1:0] inc_ff, inc_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   dbd_daynum #(.MAX_YEAR(MAX_YEAR)) u_from (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .day       (req_start_day),
      .month     (req_start_month),
      .year      (req_start_year),
      .out_valid (from_valid),
      .result    (from_num)
   );

   dbd_daynum #(.MAX_YEAR(MAX_YEAR)) u_to (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .day       (req_end_day),
      .month     (req_end_month),
      .year      (req_end_year),
      .out_valid (to_valid),
      .result    (to_num)
   );

   // end-day flag rides alongside the day-number stages
   assign inc_in = {inc_ff[INC_STAGES-2:0], req_include_end_day};

   always_ff @(posedge clock) begin
      inc_ff <= inc_in;
   end

   dbd_diff u_diff (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (from_valid && to_valid),
      .from_date   (from_num),
      .to_date     (to_num),
      .include_end (inc_ff[INC_STAGES-1]),
      .out_valid   (rsp_valid),
      .count       (rsp_day_count),
      .invalid     (rsp_date_invalid)
   );

endmodule

@@ dv/dbd_checker.sv @@
// Checker for the date difference block: predicts each result and compares it with the DUT.
module dbd_checker
   import dbd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [DAY_W-1:0]   req_start_day,
   input  logic [MONTH_W-1:0] req_start_month,
   input  logic [YEAR_W-1:0]  req_start_year,
   input  logic [DAY_W-1:0]   req_end_day,
   input  logic [MONTH_W-1:0] req_end_month,
   input  logic [YEAR_W-1:0]  req_end_year,
   input  logic               req_include_end_day,
   input  logic               rsp_valid,
   input  logic [COUNT_W-1:0] rsp_day_count,
   input  logic               rsp_date_invalid,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               invalid;
   } span_result_type;

   span_result_type expected_spans[$];
   span_result_type want;
   int              errors = 0;

   function automatic bit is_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned y,
                                                 input logic [MONTH_W-1:0] m);
      int unsigned n;
      unique case (m)
         FEBRUARY:                           n = is_leap(y) ? 29 : 28;
         APRIL, JUNE, SEPTEMBER, NOVEMBER:   n = 30;
         JANUARY, MARCH, MAY, JULY, AUGUST,
         OCTOBER, DECEMBER:                  n = 31;
         default:                            n = 0;
      endcase
      return n;
   endfunction

   function automatic int unsigned days_ahead_of(input logic [MONTH_W-1:0] m);
      int unsigned n;
      unique case (m)
         JANUARY:   n = 0;
         FEBRUARY:  n = 31;
         MARCH:     n = 59;
         APRIL:     n = 90;
         MAY:       n = 120;
         JUNE:      n = 151;
         JULY:      n = 181;
         AUGUST:    n = 212;
         SEPTEMBER: n = 243;
         OCTOBER:   n = 273;
         NOVEMBER:  n = 304;
         DECEMBER:  n = 334;
         default:   n = 0;
      endcase
      return n;
   endfunction

   function automatic bit date_valid(input int unsigned d, input logic [MONTH_W-1:0] m,
                                     input int unsigned y);
      if (y < 1 || y > MAX_YEAR_DEFAULT)
         return 1'b0;
      return (d >= 1) && (d <= days_in_month(y, m));
   endfunction

   function automatic int unsigned ordinal_day(input int unsigned d,
                                               input logic [MONTH_W-1:0] m,
                                               input int unsigned y);
      int unsigned n;
      n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      n = n + days_ahead_of(m) + d;
      if (m > FEBRUARY && is_leap(y))
         n = n + 1;
      return n;
   endfunction

   function automatic span_result_type predict_span(
      input logic [DAY_W-1:0] sd, input logic [MONTH_W-1:0] sm, input logic [YEAR_W-1:0] sy,
      input logic [DAY_W-1:0] ed, input logic [MONTH_W-1:0] em, input logic [YEAR_W-1:0] ey,
      input logic inc);
      span_result_type r;
      int unsigned     a;
      int unsigned     b;
      int unsigned     n;
      r = '0;
      if (!date_valid(sd, sm, sy) || !date_valid(ed, em, ey)) begin
         r.invalid = 1'b1;
      end else begin
         a = ordinal_day(sd, sm, sy);
         b = ordinal_day(ed, em, ey);
         n = (a < b) ? (b - a) : 0;
         n = n + inc;
         r.count = n[COUNT_W-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned exp_val);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, exp_val);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            expected_spans.push_back(predict_span(req_start_day, req_start_month,
                                                  req_start_year, req_end_day,
                                                  req_end_month, req_end_year,
                                                  req_include_end_day));
         if (rsp_valid) begin
            if (expected_spans.size() == 0) begin
               report_mismatch("result with no pending transaction", rsp_day_count, 0);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_day_count !== want.count)
                  report_mismatch("day_count", rsp_day_count, want.count);
               if (rsp_date_invalid !== want.invalid)
                  report_mismatch("date_invalid", rsp_date_invalid, want.invalid);
            end
         end
      end
      fail_count    <= errors;
      pending_count <= expected_spans.size();
   end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the date difference block: clock, reset, stimulus, watchdog and verdict.
module tb_top;
   import dbd_pkg::*;

   localparam int RANDOM_ITEMS   = 1130;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [DAY_W-1:0]   req_start_day = '0;
   logic [MONTH_W-1:0] req_start_month = '0;
   logic [YEAR_W-1:0]  req_start_year = '0;
   logic [DAY_W-1:0]   req_end_day = '0;
   logic [MONTH_W-1:0] req_end_month = '0;
   logic [YEAR_W-1:0]  req_end_year = '0;
   logic               req_include_end_day = 1'b0;
   logic               rsp_valid;
   logic [COUNT_W-1:0] rsp_day_count;
   logic               rsp_date_invalid;
   int                 fail_count;
   int                 pending_count;
   int                 stall_cycles;

   days_between_dates_top u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_start_day       (req_start_day),
      .req_start_month     (req_start_month),
      .req_start_year      (req_start_year),
      .req_end_day         (req_end_day),
      .req_end_month       (req_end_month),
      .req_end_year        (req_end_year),
      .req_include_end_day (req_include_end_day),
      .rsp_valid           (rsp_valid),
      .rsp_day_count       (rsp_day_count),
      .rsp_date_invalid    (rsp_date_invalid)
   );

   dbd_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_start_day       (req_start_day),
      .req_start_month     (req_start_month),
      .req_start_year      (req_start_year),
      .req_end_day         (req_end_day),
      .req_end_month       (req_end_month),
      .req_end_year        (req_end_year),
      .req_include_end_day (req_include_end_day),
      .rsp_valid           (rsp_valid),
      .rsp_day_count       (rsp_day_count),
      .rsp_date_invalid    (rsp_date_invalid),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_span(input logic [DAY_W-1:0] sd, input logic [MONTH_W-1:0] sm,
                            input logic [YEAR_W-1:0] sy, input logic [DAY_W-1:0] ed,
                            input logic [MONTH_W-1:0] em, input logic [YEAR_W-1:0] ey,
                            input logic inc, input bit quiet);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 23) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start               <= 1'b1;
      req_start_day       <= sd;
      req_start_month     <= sm;
      req_start_year      <= sy;
      req_end_day         <= ed;
      req_end_month       <= em;
      req_end_year        <= ey;
      req_include_end_day <= inc;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic pick_year(output logic [YEAR_W-1:0] y);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 10)
         y = YEAR_W'($urandom_range(1, 5));
      else if (sel < 20)
         y = YEAR_W'($urandom_range(9995, 9999));
      else if (sel < 35)
         y = YEAR_W'(100 * $urandom_range(1, 99));
      else
         y = YEAR_W'($urandom_range(1, 9999));
   endtask

   // mostly valid; month-end days give both valid and invalid dates
   task automatic pick_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
                            output logic [YEAR_W-1:0] y);
      pick_year(y);
      m = MONTH_W'($urandom_range(1, 12));
      if ($urandom_range(0, 99) < 80)
         d = DAY_W'($urandom_range(1, 28));
      else
         d = DAY_W'($urandom_range(28, 31));
   endtask

   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [DAY_W-1:0]   sd;
      logic [MONTH_W-1:0] sm;
      logic [YEAR_W-1:0]  sy;
      logic [DAY_W-1:0]   ed;
      logic [MONTH_W-1:0] em;
      logic [YEAR_W-1:0]  ey;
      logic               inc;
      int unsigned        sel;
      int unsigned        near_year;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_span(5'd1, JANUARY, 14'd1, 5'd31, DECEMBER, 14'd9999, 1'b0, 1'b0);
      send_span(5'd1, JANUARY, 14'd1, 5'd31, DECEMBER, 14'd9999, 1'b1, 1'b0);
      send_span(5'd31, DECEMBER, 14'd9999, 5'd1, JANUARY, 14'd1, 1'b1, 1'b0);
      send_span(5'd15, JUNE, 14'd2020, 5'd15, JUNE, 14'd2020, 1'b0, 1'b0);
      send_span(5'd15, JUNE, 14'd2020, 5'd15, JUNE, 14'd2020, 1'b1, 1'b0);
      send_span(5'd29, FEBRUARY, 14'd2000, 5'd1, MARCH, 14'd2000, 1'b0, 1'b0);
      send_span(5'd29, FEBRUARY, 14'd1900, 5'd1, MARCH, 14'd1900, 1'b0, 1'b0);
      send_span(5'd29, FEBRUARY, 14'd2024, 5'd28, FEBRUARY, 14'd2025, 1'b1, 1'b0);
      send_span(5'd1, JANUARY, 14'd2023, 5'd29, FEBRUARY, 14'd2023, 1'b0, 1'b0);
      send_span(5'd28, FEBRUARY, 14'd2100, 5'd1, MARCH, 14'd2100, 1'b0, 1'b0);
      send_span(5'd10, 4'd0, 14'd2000, 5'd10, MAY, 14'd2001, 1'b0, 1'b0);
      send_span(5'd10, MAY, 14'd2000, 5'd10, 4'd13, 14'd2001, 1'b1, 1'b0);
      send_span(5'd31, 4'd15, 14'd500, 5'd1, JULY, 14'd600, 1'b0, 1'b0);
      send_span(5'd1, JULY, 14'd500, 5'd0, JULY, 14'd600, 1'b0, 1'b0);
      send_span(5'd31, APRIL, 14'd2021, 5'd1, JUNE, 14'd2021, 1'b0, 1'b0);
      send_span(5'd30, APRIL, 14'd2021, 5'd31, MAY, 14'd2021, 1'b0, 1'b0);
      send_span(5'd1, JANUARY, 14'd0, 5'd1, JANUARY, 14'd2, 1'b0, 1'b0);
      send_span(5'd1, JANUARY, 14'd9998, 5'd1, JANUARY, 14'd10000, 1'b0, 1'b0);
      send_span(5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383, 1'b1, 1'b0);
      send_span(5'd31, DECEMBER, 14'd1999, 5'd1, JANUARY, 14'd2000, 1'b1, 1'b0);
      send_span(5'd1, JANUARY, 14'd1, 5'd2, JANUARY, 14'd1, 1'b0, 1'b0);
      send_span(5'd31, JANUARY, 14'd9999, 5'd31, DECEMBER, 14'd9999, 1'b1, 1'b0);

      // random
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 12) begin
            sd = DAY_W'($urandom_range(0, 31));
            sm = MONTH_W'($urandom_range(0, 15));
            sy = YEAR_W'($urandom_range(0, 16383));
            ed = DAY_W'($urandom_range(0, 31));
            em = MONTH_W'($urandom_range(0, 15));
            ey = YEAR_W'($urandom_range(0, 16383));
         end else begin
            pick_date(sd, sm, sy);
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
               pick_date(ed, em, ey);
            end else if (sel < 85) begin
               pick_date(ed, em, ey);
               near_year = sy + $urandom_range(0, 2);
               if (near_year > 9999)
                  near_year = 9999;
               if ($urandom_range(0, 3) == 0 && sy > 1)
                  near_year = sy - 1;
               ey = YEAR_W'(near_year);
            end else begin
               ey = sy;
               em = sm;
               ed = DAY_W'($urandom_range(1, 28));
            end
         end
         inc = 1'($urandom_range(0, 1));
         if (n == 300) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_count != 0)
               @(posedge clock);
         end
         send_span(sd, sm, sy, ed, em, ey, inc, (n >= 500 && n < 700));
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/dbd_pkg.sv
rtl/dbd_daynum.sv
rtl/dbd_diff.sv
rtl/days_between_dates_top.sv
dv/dbd_checker.sv
dv/tb_top.sv
